[rtl/dsn_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dsn_pkg
// Shared types and constants of the delayed spiking network engine.
// ----------------------------------------------------------------------------
package dsn_pkg;

  localparam int ACT_W  = 24;
  localparam int SUM_W  = 24;
  localparam int PROD_W = 31;
  localparam int THR_W  = 16;
  localparam int PER_W  = 8;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_STIM    = 2'd1,
    CMD_LINK    = 2'd2,
    CMD_TYPE    = 2'd3
  } cmd_t;

  localparam logic [7:0] REG_THRESHOLD  = 8'd0;
  localparam logic [7:0] REG_SPIKE_VAL  = 8'd1;
  localparam logic [7:0] REG_LEAK       = 8'd2;
  localparam logic [7:0] REG_REFRACTORY = 8'd3;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_WRED,
    ST_P1,
    ST_P2T,
    ST_SUM,
    ST_DRAIN,
    ST_APPLY,
    ST_MUL,
    ST_DSTART,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [THR_W-1:0]  divisor;
    logic [PER_W-1:0]  limit;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [PER_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

[rtl/delayed_spiking_network_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// delayed_spiking_network_step
// Leaky integrate-and-fire network with axonal delays, one shared sequencer.
// ----------------------------------------------------------------------------
// commands: stimulate and type commands go straight to the result, connection writes
//   first reduce the delay modulo the ring length; tick: a firing pass over all neurons,
//   then per target a skip if refractory, else link reads over all sources plus a divider run for a positive sum
// one request at a time; a new request waits until the result has been taken
// reset: a clearing pass over all NEURONS*NEURONS entries zeroes the link memory
//   before the first request is taken; configuration writes are taken at once
module delayed_spiking_network_step #(
  parameter int NEURONS  = 32,
  parameter int RING_LEN = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // neuron[4:0], source[9:5], delay[13:10], enable[14], gain[18:15], zero fill
  input  wire logic [23:0] s_tdata,
  // cmd[1:0]
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // spike_count[5:0], fired_mask[37:6], zero fill
  output logic [39:0]      m_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import dsn_pkg::*;

  localparam int NW    = $clog2(NEURONS);
  localparam int RW    = $clog2(RING_LEN);
  localparam int LINKS = NEURONS * NEURONS;
  localparam int LA_W  = $clog2(LINKS);
  localparam int LD_W  = RW + 1;

  state_t state, state_next;

  logic [THR_W-1:0] thr;
  logic [THR_W-1:0] spike_val;
  logic [PER_W-1:0] leak_max;
  logic [PER_W-1:0] refr_period;

  logic signed [ACT_W-1:0] act [NEURONS];
  logic [PER_W-1:0]        refr [NEURONS];
  logic [PER_W-1:0]        leak [NEURONS];
  logic [RING_LEN-1:0]     ring [NEURONS];
  logic [NEURONS-1:0]      exc;
  logic [RW-1:0]           ptr;

  logic [1:0]       c_cmd;
  logic [NW-1:0]    c_n;
  logic [NW-1:0]    c_src;
  logic [6:0]       c_dly;
  logic             c_en;
  logic [3:0]       c_gain;
  logic             c_ok_n;
  logic             c_ok_src;

  logic [NW-1:0]    cnt_s;
  logic [NW-1:0]    cnt_t;
  logic [NW-1:0]    s_d;
  logic             rd_pend;
  logic [LA_W-1:0]  clr_addr;

  logic signed [SUM_W-1:0] sum;
  logic [PROD_W-1:0]       prod;
  logic [5:0]              count;
  logic [31:0]             mask;

  logic            ram_we;
  logic [LA_W-1:0] ram_waddr;
  logic [LD_W-1:0] ram_wdata;
  logic [LA_W-1:0] ram_raddr;
  logic [LD_W-1:0] ram_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [6:0]  n_ext;
  logic [6:0]  src_ext;
  logic [6:0]  s7;
  logic        accept;
  logic        fire;
  logic [19:0] stim;
  logic [RW:0] pos_raw;
  logic [RW-1:0] pos;
  logic        hit;
  logic signed [ACT_W:0] act_wide;
  logic signed [ACT_W-1:0] act_sat;
  logic        sum_pos;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (state == ST_IDLE) && !m_tvalid;
  assign cfg_ready = 1'b1;
  assign n_ext     = {2'b00, s_tdata[4:0]};
  assign src_ext   = {2'b00, s_tdata[9:5]};
  assign s7        = 7'(cnt_s);

  assign fire = $signed({act[cnt_s][ACT_W-1], act[cnt_s]}) >=
                $signed({{(ACT_W+1-THR_W){1'b0}}, thr});
  assign stim = 20'(thr) * 20'(c_gain);

  assign pos_raw = {1'b0, ptr} + {1'b0, ram_rdata[RW-1:0]};
  assign pos     = (pos_raw >= (RW+1)'(RING_LEN)) ?
                   RW'(pos_raw - (RW+1)'(RING_LEN)) : pos_raw[RW-1:0];
  assign hit     = rd_pend && ram_rdata[RW] && ring[s_d][pos];

  assign act_wide = {act[cnt_t][ACT_W-1], act[cnt_t]} + {sum[SUM_W-1], sum};
  assign act_sat  = (act_wide[ACT_W] != act_wide[ACT_W-1]) ?
                    (act_wide[ACT_W] ? {1'b1, {(ACT_W-1){1'b0}}}
                                     : {1'b0, {(ACT_W-1){1'b1}}})
                    : act_wide[ACT_W-1:0];
  assign sum_pos  = !sum[SUM_W-1] && (sum != '0);

  // link memory: {enable, delay reduced modulo ring length}
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    if (state == ST_WRED && c_dly < 7'(RING_LEN) && c_ok_n && c_ok_src) begin
      ram_we    = 1'b1;
      ram_waddr = LA_W'(c_src) * LA_W'(NEURONS) + LA_W'(c_n);
      ram_wdata = {c_en, c_dly[RW-1:0]};
    end else if (state == ST_CLEAR) begin
      ram_we = 1'b1;
    end
  end

  assign ram_raddr = LA_W'(cnt_s) * LA_W'(NEURONS) + LA_W'(cnt_t);

  dsn_ram #(.WIDTH(LD_W), .DEPTH(LINKS)) u_links (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign div_req.start    = (state == ST_DSTART);
  assign div_req.dividend = prod;
  assign div_req.divisor  = thr;
  assign div_req.limit    = leak_max;

  dsn_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_addr == LA_W'(LINKS - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (accept) state_next = ST_EXEC;
      ST_EXEC: begin
        unique case (cmd_t'(c_cmd))
          CMD_TICK: state_next = ST_P1;
          CMD_LINK: state_next = ST_WRED;
          default:  state_next = ST_DONE;
        endcase
      end
      ST_WRED:   if (c_dly < 7'(RING_LEN)) state_next = ST_DONE;
      ST_P1:     if (cnt_s == NW'(NEURONS - 1)) state_next = ST_P2T;
      ST_P2T: begin
        if (refr[cnt_t] != '0) begin
          state_next = (cnt_t == NW'(NEURONS - 1)) ? ST_DONE : ST_P2T;
        end else begin
          state_next = ST_SUM;
        end
      end
      ST_SUM:    if (cnt_s == NW'(NEURONS - 1)) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_APPLY;
      ST_APPLY: begin
        if (sum_pos) begin
          state_next = ST_MUL;
        end else begin
          state_next = (cnt_t == NW'(NEURONS - 1)) ? ST_DONE : ST_P2T;
        end
      end
      ST_MUL:    state_next = ST_DSTART;
      ST_DSTART: state_next = ST_DIV;
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = (cnt_t == NW'(NEURONS - 1)) ? ST_DONE : ST_P2T;
        end
      end
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      thr         <= 16'd100;
      spike_val   <= 16'd100;
      leak_max    <= 8'd3;
      refr_period <= 8'd2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_THRESHOLD:  thr         <= cfg_data;
        REG_SPIKE_VAL:  spike_val   <= cfg_data;
        REG_LEAK:       leak_max    <= cfg_data[7:0];
        REG_REFRACTORY: refr_period <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // control counters and result
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      m_tvalid <= 1'b0;
      rd_pend  <= 1'b0;
      ptr      <= RW'(RING_LEN - 1);
      exc      <= '1;
    end else begin
      rd_pend <= (state == ST_SUM);
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + LA_W'(1);
      end
      if (state == ST_EXEC && cmd_t'(c_cmd) == CMD_TYPE && c_ok_n) begin
        exc[c_n] <= c_en;
      end
      if (state == ST_P1 && cnt_s == NW'(NEURONS - 1)) begin
        ptr <= (ptr == '0) ? RW'(RING_LEN - 1) : ptr - RW'(1);
      end
      if (state == ST_DONE) begin
        m_tvalid <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NEURONS; i++) begin
        act[i]  <= '0;
        refr[i] <= '0;
        leak[i] <= '0;
        ring[i] <= '0;
      end
    end else begin
      s_d <= cnt_s;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            c_cmd    <= s_tuser;
            c_n      <= n_ext[NW-1:0];
            c_src    <= src_ext[NW-1:0];
            c_dly    <= {3'b000, s_tdata[13:10]};
            c_en     <= s_tdata[14];
            c_gain   <= s_tdata[18:15];
            c_ok_n   <= n_ext < 7'(NEURONS);
            c_ok_src <= src_ext < 7'(NEURONS);
          end
        end
        ST_EXEC: begin
          count <= '0;
          mask  <= '0;
          cnt_s <= '0;
          if (cmd_t'(c_cmd) == CMD_STIM && c_ok_n) begin
            act[c_n] <= ACT_W'(stim);
            if (c_gain != '0) begin
              leak[c_n] <= leak_max;
            end
          end
        end
        ST_WRED: begin
          if (c_dly >= 7'(RING_LEN)) begin
            c_dly <= c_dly - 7'(RING_LEN);
          end
        end
        ST_P1: begin
          if (fire) begin
            ring[cnt_s][ptr] <= 1'b1;
            refr[cnt_s]      <= refr_period;
            if (count != 6'd63) begin
              count <= count + 6'd1;
            end
            if (s7 < 7'd32) begin
              mask[s7[4:0]] <= 1'b1;
            end
          end else begin
            ring[cnt_s][ptr] <= 1'b0;
          end
          if (fire || leak[cnt_s] == '0) begin
            act[cnt_s] <= '0;
          end
          if (leak[cnt_s] != '0) begin
            leak[cnt_s] <= leak[cnt_s] - PER_W'(1);
          end
          cnt_s <= cnt_s + NW'(1);
          cnt_t <= '0;
        end
        ST_P2T: begin
          cnt_s <= '0;
          sum   <= '0;
          if (refr[cnt_t] != '0) begin
            refr[cnt_t] <= refr[cnt_t] - PER_W'(1);
            cnt_t       <= cnt_t + NW'(1);
          end
        end
        ST_SUM, ST_DRAIN: begin
          if (state == ST_SUM) begin
            cnt_s <= cnt_s + NW'(1);
          end
          if (hit) begin
            sum <= exc[s_d] ? sum + SUM_W'(spike_val) : sum - SUM_W'(spike_val);
          end
        end
        ST_APPLY: begin
          act[cnt_t] <= act_sat;
          if (!sum_pos) begin
            cnt_t <= cnt_t + NW'(1);
          end
        end
        ST_MUL: begin
          prod <= {8'b0, sum[SUM_W-2:0]} * {23'b0, leak_max};
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            leak[cnt_t] <= div_rsp.quotient;
            cnt_t       <= cnt_t + NW'(1);
          end
        end
        ST_DONE: begin
          m_tdata <= {2'b00, mask, count};
        end
        default: ;
      endcase
    end
  end

  a_ready_no_result: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid) else $error("ready while a result waits");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready) else $error("second request taken during work");
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (!m_tvalid && !s_tready))
    else $error("activity during clearing pass");
  a_div_owned: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIV)) else $error("stray divider result");
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_DONE))
    else $error("result outside done step");

endmodule
`default_nettype wire

[rtl/dsn_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dsn_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dsn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/dsn_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dsn_div
// Shift-subtract divider, one quotient bit a cycle, result clipped to a limit.
// ----------------------------------------------------------------------------
module dsn_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dsn_pkg::div_req_t req,
  output dsn_pkg::div_rsp_t      rsp
);
  import dsn_pkg::*;

  logic [PROD_W-1:0]      rem;
  logic [THR_W+PER_W-1:0] dsh;
  logic [PER_W-1:0]       q;
  logic [PER_W-1:0]       lim;
  logic [2:0]             step;
  logic                   run;
  logic                   done;
  logic [PER_W-1:0]       qout;
  logic                   ge;
  logic [PER_W-1:0]       q_new;

  assign ge    = rem >= PROD_W'(dsh);
  assign q_new = {q[PER_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        lim <= req.limit;
        if (req.divisor == '0 ||
            req.dividend >= PROD_W'({req.divisor, {PER_W{1'b0}}})) begin
          qout <= req.limit;
          done <= 1'b1;
        end else begin
          rem  <= req.dividend;
          dsh  <= (THR_W+PER_W)'(req.divisor) << (PER_W-1);
          q    <= '0;
          step <= 3'd7;
          run  <= 1'b1;
        end
      end else if (run) begin
        if (ge) begin
          rem <= rem - PROD_W'(dsh);
        end
        q   <= q_new;
        dsh <= dsh >> 1;
        step <= step - 3'd1;
        if (step == 3'd0) begin
          run  <= 1'b0;
          done <= 1'b1;
          qout <= (q_new > lim) ? lim : q_new;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = qout;

endmodule
`default_nettype wire
